/* sv/nps_pkg.sv */
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types, constants and helpers for the nearest palette colour search.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

    // Field widths
    localparam int COLOR_W = 8;
    localparam int IDX_W   = 8;

    // Parameter defaults
    localparam int REDUCED_BITS_DEF  = 6;
    localparam int PALETTE_DEPTH_DEF = 256;

    // Cell row: entry index = {group, cell number}
    localparam int CELL_COUNT = 8;
    localparam int CELL_BITS  = $clog2(CELL_COUNT);
    localparam int GRP_W      = IDX_W - CELL_BITS;

    // Searched range: first..gap start, gap end..search end (exclusive ends)
    localparam logic [IDX_W-1:0] SEARCH_FIRST = 8'd1;
    localparam logic [IDX_W-1:0] GAP_START    = 8'd198;
    localparam logic [IDX_W-1:0] GAP_END      = 8'd206;
    localparam logic [IDX_W-1:0] SEARCH_END   = 8'd215;

    // Distance widths: weighted sum and sum scaled down by 256
    localparam int SQ_W   = 2 * COLOR_W;
    localparam int WT_W   = 10;
    localparam int SUM_W  = 28;
    localparam int DIST_W = SUM_W - 8;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
    } color_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [GRP_W-1:0] grp;
        color_t           col;
    } tok_t;

    // Running best handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              found;
        logic [DIST_W-1:0] metric;
        logic [IDX_W-1:0]  idx;
    } res_t;

    // Palette write broadcast to all cells
    typedef struct packed {
        logic                 en;
        logic [CELL_BITS-1:0] cell_sel;
        logic [GRP_W-1:0]     grp;
        color_t               data;
    } wr_t;

    // True for entries that take part in the search
    function automatic logic is_searched(input logic [IDX_W-1:0] idx);
        return ((idx >= SEARCH_FIRST) && (idx < GAP_START)) ||
               ((idx >= GAP_END) && (idx < SEARCH_END));
    endfunction

endpackage

`default_nettype wire

/* sv/nearest_palette_colour_search.sv */
// ----------------------------------------------------------------------------
// nearest_palette_colour_search: weighted-RGB nearest palette entry search
// Write transaction: a new one accepted every cycle while no query is in flight.
// Query: the 8-cell row is scanned one group per cycle, then drained; the next
// item is accepted with the result, or later while an earlier result still waits.
// Reset clears control only; palette entries are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_colour_search
    import nps_pkg::*;
#(
    parameter int REDUCED_BITS  = REDUCED_BITS_DEF,
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               operation,
    input  wire logic [IDX_W-1:0]   entry_index,
    input  wire logic [COLOR_W-1:0] red,
    input  wire logic [COLOR_W-1:0] green,
    input  wire logic [COLOR_W-1:0] blue,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [IDX_W-1:0]        nearest_index
);

    localparam int DROP       = COLOR_W - REDUCED_BITS;
    localparam logic [COLOR_W-1:0] KEEP_MASK =
        ~((COLOR_W'(1) << DROP) - COLOR_W'(1));
    localparam logic [COLOR_W-1:0] MID_BIT = COLOR_W'(1) << (DROP - 1);
    localparam int SCAN_LIMIT =
        (PALETTE_DEPTH < int'(SEARCH_END)) ? PALETTE_DEPTH : int'(SEARCH_END);
    localparam int GROUPS     = (SCAN_LIMIT + CELL_COUNT - 1) / CELL_COUNT;
    localparam logic [GRP_W-1:0] LAST_GRP  = GRP_W'(GROUPS - 1);
    localparam logic [IDX_W:0]   DEPTH_LIM = (IDX_W + 1)'(PALETTE_DEPTH);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_DRAIN   = 2'd2;
    localparam logic [1:0] ST_DELIVER = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [GRP_W-1:0]  grp_reg, grp_next;
    color_t            col_reg, col_next;
    tok_t              tok_reg, tok_next;
    logic              acc_found_reg, acc_found_next;
    logic [DIST_W-1:0] acc_dist_reg, acc_dist_next;
    logic [IDX_W-1:0]  acc_idx_reg, acc_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic              in_fire;
    logic              query_start;
    wr_t               wr;
    tok_t              tok_link [CELL_COUNT+1];
    res_t              res_link [CELL_COUNT+1];

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign query_start = in_fire && (operation == OP_QUERY);

    // Broadcast palette writes; drop writes beyond the palette
    always_comb
    begin
        wr.en       = in_fire && (operation == OP_WRITE) &&
                      ({1'b0, entry_index} < DEPTH_LIM);
        wr.cell_sel = entry_index[CELL_BITS-1:0];
        wr.grp      = entry_index[IDX_W-1:CELL_BITS];
        wr.data     = '{r: red, g: green, b: blue};
    end

    // Sequencer: issue one group per cycle, wait for the row to drain, then deliver
    always_comb
    begin
        state_next     = state_reg;
        grp_next       = grp_reg;
        col_next       = col_reg;
        tok_next.valid = 1'b0;
        tok_next.last  = (grp_reg == LAST_GRP);
        tok_next.grp   = grp_reg;
        tok_next.col   = col_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_idx_next   = out_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_start)
                begin
                    state_next = ST_SCAN;
                    grp_next   = '0;
                    col_next.r = (red & KEEP_MASK) | MID_BIT;
                    col_next.g = (green & KEEP_MASK) | MID_BIT;
                    col_next.b = (blue & KEEP_MASK) | MID_BIT;
                end
            end
            ST_SCAN:
            begin
                tok_next.valid = 1'b1;
                grp_next       = grp_reg + GRP_W'(1);
                if (grp_reg == LAST_GRP)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (res_link[CELL_COUNT].valid && res_link[CELL_COUNT].last)
                begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = acc_idx_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Fold each group's best into the query's best; earlier groups win ties
    always_comb
    begin
        acc_found_next = acc_found_reg;
        acc_dist_next  = acc_dist_reg;
        acc_idx_next   = acc_idx_reg;
        if (query_start)
        begin
            acc_found_next = 1'b0;
            acc_idx_next   = '0;
        end
        else if (res_link[CELL_COUNT].valid && res_link[CELL_COUNT].found &&
                 (!acc_found_reg || (res_link[CELL_COUNT].metric < acc_dist_reg)))
        begin
            acc_found_next = 1'b1;
            acc_dist_next  = res_link[CELL_COUNT].metric;
            acc_idx_next   = res_link[CELL_COUNT].idx;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tok_reg       <= '0;
            acc_found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tok_reg       <= tok_next;
            acc_found_reg <= acc_found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        grp_reg      <= grp_next;
        col_reg      <= col_next;
        acc_dist_reg <= acc_dist_next;
        acc_idx_reg  <= acc_idx_next;
        out_idx_reg  <= out_idx_next;
    end

    // Cell row: tokens and running best move one cell per cycle
    assign tok_link[0] = tok_reg;
    assign res_link[0] = '0;

    for (genvar c = 0; c < CELL_COUNT; c++)
    begin : g_cell
        nps_cell #(
            .PALETTE_DEPTH (PALETTE_DEPTH),
            .CELL_ID       (c)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (wr),
            .tok_in  (tok_link[c]),
            .res_in  (res_link[c]),
            .tok_out (tok_link[c+1]),
            .res_out (res_link[c+1])
        );
    end

    assign out_valid     = out_valid_reg;
    assign nearest_index = out_idx_reg;

    // A group result leaves the row only while a query is in flight
    a_res_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        res_link[CELL_COUNT].valid |-> (state_reg == ST_SCAN) || (state_reg == ST_DRAIN))
        else $error("row result outside a query");

    // The last group result arrives only after the scan has ended
    a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (res_link[CELL_COUNT].valid && res_link[CELL_COUNT].last) |->
        (state_reg == ST_DRAIN))
        else $error("last group result before scan end");

    // Tokens are issued only during a query
    a_tok_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        tok_reg.valid |-> (state_reg == ST_SCAN) || (state_reg == ST_DRAIN))
        else $error("token issued outside a query");

    // Every query finds at least one searched entry before delivery
    a_found_on_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DELIVER) |-> acc_found_reg)
        else $error("delivering a query with no candidate");

endmodule

`default_nettype wire

/* sv/nps_cell.sv */
// ----------------------------------------------------------------------------
// nps_cell
// One search cell: a palette bank, a distance pipeline and a compare stage
// that folds its entry into the running best handed on from the left.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_cell
    import nps_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
    parameter int CELL_ID       = 0
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire wr_t  wr,
    input  wire tok_t tok_in,
    input  wire res_t res_in,
    output tok_t      tok_out,
    output res_t      res_out
);

    localparam int BANK_DEPTH = (PALETTE_DEPTH + CELL_COUNT - 1) / CELL_COUNT;
    localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam logic [CELL_BITS-1:0] MY_CELL = CELL_BITS'(CELL_ID);
    localparam logic [IDX_W:0]       DEPTH_LIM = (IDX_W + 1)'(PALETTE_DEPTH);

    typedef struct packed {
        logic             valid;
        logic             last;
        logic             srch;
        logic [IDX_W-1:0] idx;
        logic [COLOR_W-1:0] avg;
        logic [SQ_W-1:0]  sqr;
        logic [SQ_W-1:0]  sqg;
        logic [SQ_W-1:0]  sqb;
    } sq_stage_t;

    typedef struct packed {
        logic                    valid;
        logic                    last;
        logic                    srch;
        logic [IDX_W-1:0]        idx;
        logic [SQ_W+WT_W-1:0]    wr;
        logic [SQ_W+WT_W-1:0]    wg;
        logic [SQ_W+WT_W-1:0]    wb;
    } wt_stage_t;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic              srch;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] metric;
    } dist_stage_t;

    color_t      bank [BANK_DEPTH];
    color_t      rd_reg;
    tok_t        s1_reg;
    sq_stage_t   s2_reg, s2_next;
    wt_stage_t   s3_reg, s3_next;
    dist_stage_t s4_reg, s4_next;
    res_t        res_reg, res_next;

    // Write the bank and read the entry of the incoming group
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.cell_sel == MY_CELL))
        begin
            bank[wr.grp[ADDR_W-1:0]] <= wr.data;
        end
        rd_reg <= bank[tok_in.grp[ADDR_W-1:0]];
    end

    // Stage 2: channel differences, squares and red average
    always_comb
    begin
        logic [COLOR_W:0]   rsum;
        logic [COLOR_W-1:0] dr, dg, db;
        logic [IDX_W-1:0]   idx;
        rsum = {1'b0, rd_reg.r} + {1'b0, s1_reg.col.r};
        dr = (rd_reg.r > s1_reg.col.r) ? rd_reg.r - s1_reg.col.r : s1_reg.col.r - rd_reg.r;
        dg = (rd_reg.g > s1_reg.col.g) ? rd_reg.g - s1_reg.col.g : s1_reg.col.g - rd_reg.g;
        db = (rd_reg.b > s1_reg.col.b) ? rd_reg.b - s1_reg.col.b : s1_reg.col.b - rd_reg.b;
        idx = {s1_reg.grp, MY_CELL};
        s2_next.valid = s1_reg.valid;
        s2_next.last  = s1_reg.last;
        s2_next.idx   = idx;
        s2_next.srch  = is_searched(idx) && ({1'b0, idx} < DEPTH_LIM);
        s2_next.avg   = rsum[COLOR_W:1];
        s2_next.sqr   = {{COLOR_W{1'b0}}, dr} * {{COLOR_W{1'b0}}, dr};
        s2_next.sqg   = {{COLOR_W{1'b0}}, dg} * {{COLOR_W{1'b0}}, dg};
        s2_next.sqb   = {{COLOR_W{1'b0}}, db} * {{COLOR_W{1'b0}}, db};
    end

    // Stage 3: weight each squared difference
    always_comb
    begin
        logic [WT_W-1:0] kr, kb;
        kr = WT_W'(512) + {2'b00, s2_reg.avg};
        kb = WT_W'(767) - {2'b00, s2_reg.avg};
        s3_next.valid = s2_reg.valid;
        s3_next.last  = s2_reg.last;
        s3_next.srch  = s2_reg.srch;
        s3_next.idx   = s2_reg.idx;
        s3_next.wr    = kr * s2_reg.sqr;
        s3_next.wg    = {s2_reg.sqg, 10'b0};
        s3_next.wb    = kb * s2_reg.sqb;
    end

    // Stage 4: add the terms and drop the scale of 256
    always_comb
    begin
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(s3_reg.wr) + SUM_W'(s3_reg.wg) + SUM_W'(s3_reg.wb);
        s4_next.valid  = s3_reg.valid;
        s4_next.last   = s3_reg.last;
        s4_next.srch   = s3_reg.srch;
        s4_next.idx    = s3_reg.idx;
        s4_next.metric = sum[SUM_W-1:8];
    end

    // Compare: take this entry when none is found yet or on a strictly smaller distance
    always_comb
    begin
        logic take;
        take = s4_reg.valid && s4_reg.srch &&
               (!res_in.found || (s4_reg.metric < res_in.metric));
        res_next.valid  = s4_reg.valid;
        res_next.last   = s4_reg.last;
        res_next.found  = res_in.found || take;
        res_next.metric = take ? s4_reg.metric : res_in.metric;
        res_next.idx    = take ? s4_reg.idx : res_in.idx;
    end

    // Advance the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            s2_reg  <= '0;
            s3_reg  <= '0;
            s4_reg  <= '0;
            res_reg <= '0;
        end
        else
        begin
            s1_reg  <= tok_in;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            s4_reg  <= s4_next;
            res_reg <= res_next;
        end
    end

    assign tok_out = s1_reg;
    assign res_out = res_reg;

endmodule

`default_nettype wire
